/* rtl/core/btp_pkg.sv */
// btp_pkg: shared types and constants for the binary thinning pass
// used by btp_rule and binary_thinning_pass; depends on nothing else
package btp_pkg;

    // 3x3 neighborhood, three columns of three rows, oldest column in the low bits
    typedef logic [8:0] t_window;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SUB_PASS     = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } t_reg_idx;

    localparam int CFG_W       = 11;
    localparam int RESET_WIDTH = 640;
    localparam int RESET_HEIGHT = 480;

    // stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

endpackage

/* rtl/core/btp_rule.sv */
// btp_rule: zhang-suen deletion test on one 3x3 window
// depends on btp_pkg for the window type
module btp_rule (
    input  btp_pkg::t_window i_win,
    input  logic             i_sub_pass,
    output logic             o_removable
);
    import btp_pkg::*;

    logic [7:0] nb;
    logic [7:0] trans;
    logic [3:0] n_trans;
    logic [3:0] n_set;
    logic       prod_a;
    logic       prod_b;

    // neighbors p2..p9 going round the center
    assign nb = {i_win[0], i_win[1], i_win[2], i_win[5],
                 i_win[8], i_win[7], i_win[6], i_win[3]};

    // 0-to-1 transitions and set-neighbor count
    always_comb begin
        n_trans = '0;
        n_set   = '0;
        for (int k = 0; k < 8; k++) begin
            trans[k] = !nb[k] && nb[(k + 1) % 8];
            n_trans  = n_trans + 4'(trans[k]);
            n_set    = n_set + 4'(nb[k]);
        end
    end

    // sub-pass products: nb[0]=p2 nb[2]=p4 nb[4]=p6 nb[6]=p8
    always_comb begin
        if (i_sub_pass) begin
            prod_a = nb[0] & nb[2] & nb[6];
            prod_b = nb[0] & nb[4] & nb[6];
        end else begin
            prod_a = nb[0] & nb[2] & nb[4];
            prod_b = nb[2] & nb[4] & nb[6];
        end
    end

    assign o_removable = (n_trans == 4'd1) && (n_set >= 4'd2) && (n_set <= 4'd6)
                         && !prod_a && !prod_b;

endmodule

/* rtl/core/binary_thinning_pass.sv */
// binary_thinning_pass: one zhang-suen thinning sub-pass on a raster binary stream
// depends on btp_pkg and btp_rule
//
// Usage: pixels enter on the s_axis group one per request in raster order, pixel in
// tdata[0], tuser[0] = frame start, tuser[1] = drain (dummy pixel read as 0).
// Results leave on the m_axis group: tdata[0] = new pixel value, tdata[1] = removed
// flag, tlast on the frame's last pixel. The result for a pixel comes out after
// width+1 further input requests; width+1 drain requests flush the frame tail.
// Each request passes a line-store read stage and then the output register before
// its result is valid on m_axis. One request per cycle is sustained while m_axis
// does not stall; the line store is one read and one write port per cycle.
// When m_axis stalls, the output register and the read stage hold and s_axis_tready
// drops only once both are full. Reset clears counters, window and registers
// (sub_pass 0, 640 x 480); the line store is not cleared and needs no warm-up.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once and
// are to be made only while the stream is idle.
module binary_thinning_pass #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [btp_pkg::CFG_W-1:0]     i_cfg_data,
    // pixel input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [btp_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [0] pixel_in
    input  logic [btp_pkg::S_TUSER_W-1:0] s_axis_tuser,  // [0] frame_start, [1] drain
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [btp_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [0] pixel_out, [1] was_removed
    output logic                          m_axis_tlast   // frame_last
);
    import btp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int XW = (WW > CFG_W) ? WW : CFG_W;
    localparam int XH = (RW > CFG_W) ? RW : CFG_W;

    // configuration registers
    logic             r_sub_pass;
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_pass     <= 1'b0;
            r_frame_width  <= CFG_W'(RESET_WIDTH);
            r_frame_height <= CFG_W'(RESET_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SUB_PASS:     r_sub_pass     <= i_cfg_data[0];
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp frame size to 1..max
    logic [XW-1:0] fw_x;
    logic [XH-1:0] fh_x;
    logic [WW-1:0] w;
    logic [RW-1:0] h;

    assign fw_x = XW'(r_frame_width);
    assign fh_x = XH'(r_frame_height);

    always_comb begin
        if (fw_x == '0) begin
            w = WW'(1);
        end else if (fw_x > XW'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(fw_x);
        end
        if (fh_x == '0) begin
            h = RW'(1);
        end else if (fh_x > XH'(MAX_HEIGHT)) begin
            h = RW'(MAX_HEIGHT);
        end else begin
            h = RW'(fh_x);
        end
    end

    // handshake and stage control
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic s1_adv;
    logic in_acc;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_adv        = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // position of the incoming pixel
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] c_in;
    logic [RW-1:0] r_in;
    logic [WW-1:0] c_inc;
    logic          pix_in;

    assign c_in   = s_axis_tuser[0] ? '0 : r_col;
    assign r_in   = s_axis_tuser[0] ? '0 : r_row;
    assign pix_in = s_axis_tdata[0] & !s_axis_tuser[1];
    assign c_inc  = WW'(c_in) + WW'(1);

    always_comb begin
        if (c_inc >= w) begin
            n_col = '0;
            if ((RW + 1)'(r_in) < (RW + 1)'(h) + (RW + 1)'(2)) begin
                n_row = r_in + RW'(1);
            end else begin
                n_row = r_in;
            end
        end else begin
            n_col = c_inc[CW-1:0];
            n_row = r_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // read stage registers
    logic [CW-1:0] r_s1_c;
    logic [RW-1:0] r_s1_r;
    logic          r_s1_pix;
    logic [1:0]    r_rd;
    logic          r_fwd;
    logic [1:0]    r_fwd_val;
    logic [1:0]    line;
    logic [1:0]    wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_c    <= c_in;
            r_s1_r    <= r_in;
            r_s1_pix  <= pix_in;
            r_fwd     <= s1_adv && (r_s1_c == c_in);
            r_fwd_val <= wr_data;
        end
    end

    // line store: bit 1 row r-2, bit 0 row r-1
    logic [1:0] mem [MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd <= mem[c_in];
        end
        if (s1_adv) begin
            mem[r_s1_c] <= wr_data;
        end
    end

    // column from the line store, with bypass of the write in flight
    assign line    = r_fwd ? r_fwd_val : r_rd;
    assign wr_data = {line[0], r_s1_pix};

    // 3x3 window shift
    t_window r_win;
    t_window nw;

    assign nw = {r_s1_pix, line[0], line[1], r_win[8:3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_adv) begin
            r_win <= nw;
        end
    end

    // decision for the delayed center pixel
    logic            rule_ok;
    logic [RW:0]     rx;
    logic [RW:0]     hx;
    logic [WW-1:0]   cx;
    logic            emit;
    logic            cval;
    logic            removed;
    logic            last;

    btp_rule u_rule (
        .i_win       (nw),
        .i_sub_pass  (r_sub_pass),
        .o_removable (rule_ok)
    );

    assign rx = (RW + 1)'(r_s1_r);
    assign hx = (RW + 1)'(h);
    assign cx = WW'(r_s1_c);

    always_comb begin
        if (r_s1_c == '0) begin
            // center is the last pixel of row r-2, still in the old window
            cval    = r_win[7];
            emit    = (rx >= (RW + 1)'(2)) && (rx < hx + (RW + 1)'(2));
            last    = (rx == hx + (RW + 1)'(1));
            removed = 1'b0;
        end else begin
            cval    = nw[4];
            emit    = (rx >= (RW + 1)'(1)) && (rx < hx + (RW + 1)'(1));
            last    = (rx == hx) && (cx == w);
            removed = cval && rule_ok
                      && (rx >= (RW + 1)'(2)) && (rx < hx)
                      && (cx >= WW'(2)) && (cx < w);
        end
    end

    // output register
    logic r_out_pix;
    logic r_out_rem;
    logic r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pix  <= cval & !removed;
            r_out_rem  <= removed;
            r_out_last <= last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - 2)'(0), r_out_rem, r_out_pix};
    assign m_axis_tlast  = r_out_last;

endmodule
